// ===== rtl/core/bisu_pkg.sv =====
// Shared constants, field widths and control types of the bilinear image sampler.
// Used by every module of the sampler; depends on nothing.
package bisu_pkg;

    localparam int PIX_W          = 32;
    localparam int COORD_W        = 13;
    localparam int POS_W          = 25;
    localparam int DIM_REG_W      = 9;
    localparam int DIM_W          = 13;
    localparam int CMD_W          = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int PIXEL_BITS     = 32;
    localparam int FRAC_BITS      = 12;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int S_FIELDS_W = 2 * COORD_W + PIX_W + 2 * POS_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_DATA_W   = PIX_W;

    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int MUL_A_W = 2 * FRAC_BITS + 1;
    localparam int MUL_B_W = PIX_W;
    localparam int ACC_W   = MUL_A_W + MUL_B_W;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INTERP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK  = 2'd2;

    localparam logic [DIM_REG_W-1:0] RST_WIDTH  = 9'd256;
    localparam logic [DIM_REG_W-1:0] RST_HEIGHT = 9'd256;
    localparam logic [PIX_W-1:0]     RST_BLANK  = 32'h8000_0000;

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_add;
    } mac_ctrl_t;

endpackage

// ===== rtl/core/bilinear_image_sampler_unit.sv =====
// Bilinear image sampler for write, read and interpolate requests; the next
// request is taken in the cycle after the result is registered. Interpolation
// time is set by four reads on the single-port pixel memory and nine steps of
// the shared multiply-accumulate unit.
// Reset clears control state and the size and marker registers; pixels are
// undefined until written. Depends on bisu_pkg, bisu_seq, bisu_pixel_mem, bisu_mac.
module bilinear_image_sampler_unit
    import bisu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // col_index[12:0], row_index[25:13], pixel_value[57:26], x_pos[82:58],
    // y_pos[107:83], zero fill
    input  logic [S_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_value[31:0]
    output logic [M_DATA_W-1:0]  m_tdata,
    // result_blank[0]
    output logic                 m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [DIM_REG_W-1:0] width_reg, width_next;
    logic [DIM_REG_W-1:0] height_reg, height_next;
    logic [PIX_W-1:0]     blank_reg, blank_next;
    logic [DIM_W-1:0]     eff_width, eff_height;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_addr;
    logic [PIX_W-1:0]     mem_wdata, mem_rdata;
    mac_ctrl_t            mac_ctrl;
    logic [MUL_A_W-1:0]   mac_opa;
    logic [MUL_B_W-1:0]   mac_opb;
    logic [ACC_W-1:0]     mac_prod, mac_acc;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        blank_next  = blank_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_next  = cfg_data[DIM_REG_W-1:0];
                CFG_HEIGHT: height_next = cfg_data[DIM_REG_W-1:0];
                CFG_BLANK:  blank_next  = cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            blank_reg  <= RST_BLANK;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            blank_reg  <= blank_next;
        end
    end

    assign eff_width  = (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH)) ?
                        DIM_W'(MAX_WIDTH) : DIM_W'(width_reg);
    assign eff_height = (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT)) ?
                        DIM_W'(MAX_HEIGHT) : DIM_W'(height_reg);

    bisu_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .eff_width    (eff_width),
        .eff_height   (eff_height),
        .blank_marker (blank_reg),
        .mem_we       (mem_we),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata),
        .mac_ctrl     (mac_ctrl),
        .mac_opa      (mac_opa),
        .mac_opb      (mac_opb),
        .mac_prod     (mac_prod),
        .mac_acc      (mac_acc)
    );

    bisu_pixel_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bisu_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .opa  (mac_opa),
        .opb  (mac_opb),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

endmodule

// ===== rtl/core/bisu_pixel_mem.sv =====
// Single-port pixel memory with registered read data.
// Depends on bisu_pkg for the pixel width.
module bisu_pixel_mem
    import bisu_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [PIX_W-1:0]         wdata,
    output logic [PIX_W-1:0]         rdata
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bisu_mac.sv =====
// Shared multiply-accumulate unit: registered product and accumulator.
// Depends on bisu_pkg for operand widths and the control struct.
module bisu_mac
    import bisu_pkg::*;
(
    input  logic               clk,
    input  mac_ctrl_t          ctrl,
    input  logic [MUL_A_W-1:0] opa,
    input  logic [MUL_B_W-1:0] opb,
    output logic [ACC_W-1:0]   prod,
    output logic [ACC_W-1:0]   acc
);

    logic [ACC_W-1:0] prod_reg;
    logic [ACC_W-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= ACC_W'(opa) * ACC_W'(opb);
        end
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ===== rtl/core/bisu_seq.sv =====
// Command sequencer: decodes requests, drives the pixel memory and the shared MAC,
// rounds the blend and holds the result register. Depends on bisu_pkg.
module bisu_seq
    import bisu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int ADDR_W    = $clog2(MAX_WIDTH * MAX_HEIGHT)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,
    input  logic [DIM_W-1:0]    eff_width,
    input  logic [DIM_W-1:0]    eff_height,
    input  logic [PIX_W-1:0]    blank_marker,
    output logic                mem_we,
    output logic [ADDR_W-1:0]   mem_addr,
    output logic [PIX_W-1:0]    mem_wdata,
    input  logic [PIX_W-1:0]    mem_rdata,
    output mac_ctrl_t           mac_ctrl,
    output logic [MUL_A_W-1:0]  mac_opa,
    output logic [MUL_B_W-1:0]  mac_opb,
    input  logic [ACC_W-1:0]    mac_prod,
    input  logic [ACC_W-1:0]    mac_acc
);

    localparam int LIN_W  = 2 * COORD_W;
    localparam int RND_W  = ACC_W - 2 * FRAC_BITS;
    localparam int SGN_W  = RND_W + 1;
    localparam logic [PIX_W-1:0] OFFSET = {1'b1, {(PIX_W - 1){1'b0}}};
    localparam logic [WGT_W-1:0] ONE    = WGT_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF   = ACC_W'(1) << (2 * FRAC_BITS - 1);
    localparam logic signed [SGN_W-1:0] SAT_HI =
        SGN_W'((longint'(1) <<< (PIXEL_BITS - 1)) - longint'(1));
    localparam logic signed [SGN_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CMD   = 7'b0000010,
        S_RDATA = 7'b0000100,
        S_FETCH = 7'b0001000,
        S_MAC   = 7'b0010000,
        S_ROUND = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [COORD_W-1:0]   col_reg, col_next;
    logic [COORD_W-1:0]   row_reg, row_next;
    logic [PIX_W-1:0]     pixel_reg, pixel_next;
    logic [POS_W-1:0]     x_reg, x_next;
    logic [POS_W-1:0]     y_reg, y_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [3:0]           step_reg, step_next;
    logic                 prev_in_reg, prev_in_next;
    logic                 blank_reg, blank_next;
    logic [PIX_W-1:0]     res_val_reg, res_val_next;
    logic                 res_blank_reg, res_blank_next;
    logic [PIX_W-1:0]     out_val_reg, out_val_next;
    logic                 out_blank_reg, out_blank_next;
    logic                 out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]     pix_reg [4];

    logic [COORD_W-1:0]   xi, yj, nb_c, nb_r, sel_c, sel_r;
    logic [FRAC_BITS-1:0] fx, fy;
    logic                 sel_neg, sel_in, interp_ok, hit;
    logic [LIN_W-1:0]     lin;
    logic [PIX_W-1:0]     cap_val;
    logic                 cap_en;
    logic [1:0]           cap_idx, k;
    logic [WGT_W-1:0]     wx, wy;
    logic [ACC_W-1:0]     rnd_sum;
    logic [RND_W-1:0]     rnd_q;
    logic signed [SGN_W-1:0] cen, sat;

    assign xi   = x_reg[POS_W-1:FRAC_BITS];
    assign yj   = y_reg[POS_W-1:FRAC_BITS];
    assign fx   = x_reg[FRAC_BITS-1:0];
    assign fy   = y_reg[FRAC_BITS-1:0];
    assign nb_c = xi + COORD_W'(cnt_reg[0]);
    assign nb_r = yj + COORD_W'(cnt_reg[1]);

    always_comb
    begin
        if (state_reg == S_FETCH)
        begin
            sel_c   = nb_c;
            sel_r   = nb_r;
            sel_neg = 1'b0;
        end
        else
        begin
            sel_c   = col_reg;
            sel_r   = row_reg;
            sel_neg = col_reg[COORD_W-1] | row_reg[COORD_W-1];
        end
    end

    assign sel_in    = !sel_neg && (sel_c < eff_width) && (sel_r < eff_height);
    assign lin       = LIN_W'(sel_r) * LIN_W'(MAX_WIDTH) + LIN_W'(sel_c);
    assign interp_ok = !x_reg[POS_W-1] && !y_reg[POS_W-1] &&
                       (xi < eff_width) && (yj < eff_height);

    assign mem_addr  = lin[ADDR_W-1:0];
    assign mem_wdata = pixel_reg;
    assign mem_we    = (state_reg == S_CMD) && (cmd_reg == CMD_WRITE) && sel_in;

    assign cap_val = prev_in_reg ? mem_rdata : '0;
    assign hit     = (cap_val == blank_marker);
    assign cap_en  = (state_reg == S_FETCH) && (cnt_reg != 3'd0);
    assign cap_idx = 2'(cnt_reg - 3'd1);

    assign k  = step_reg[2:1];
    assign wx = k[0] ? WGT_W'(fx) : ONE - WGT_W'(fx);
    assign wy = k[1] ? WGT_W'(fy) : ONE - WGT_W'(fy);
    assign mac_opa = step_reg[0] ? mac_prod[MUL_A_W-1:0] : MUL_A_W'(wx);
    assign mac_opb = step_reg[0] ? (pix_reg[k] ^ OFFSET) : MUL_B_W'(wy);

    assign rnd_sum = mac_acc + HALF;
    assign rnd_q   = rnd_sum[ACC_W-1:2*FRAC_BITS];
    assign cen     = $signed({1'b0, rnd_q}) - $signed(SGN_W'(OFFSET));
    assign sat     = (cen > SAT_HI) ? SAT_HI : ((cen < SAT_LO) ? SAT_LO : cen);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_blank_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        pixel_next     = pixel_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        prev_in_next   = prev_in_reg;
        blank_next     = blank_reg;
        res_val_next   = res_val_reg;
        res_blank_next = res_blank_reg;
        out_val_next   = out_val_reg;
        out_blank_next = out_blank_reg;
        out_valid_next = out_valid_reg;
        mac_ctrl       = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    col_next   = s_tdata[COORD_W-1:0];
                    row_next   = s_tdata[2*COORD_W-1:COORD_W];
                    pixel_next = s_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
                    x_next     = s_tdata[2*COORD_W+PIX_W+POS_W-1:2*COORD_W+PIX_W];
                    y_next     = s_tdata[S_FIELDS_W-1:2*COORD_W+PIX_W+POS_W];
                    state_next = S_CMD;
                end
            end
            S_CMD:
            begin
                blank_next   = 1'b0;
                prev_in_next = sel_in;
                cnt_next     = 3'd0;
                case (cmd_reg)
                    CMD_READ:
                    begin
                        state_next = S_RDATA;
                    end
                    CMD_INTERP:
                    begin
                        if (interp_ok)
                        begin
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            res_val_next   = '0;
                            res_blank_next = 1'b0;
                            state_next     = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RDATA:
            begin
                res_val_next   = cap_val;
                res_blank_next = 1'b0;
                state_next     = S_DONE;
            end
            S_FETCH:
            begin
                prev_in_next = sel_in;
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg != 3'd0)
                begin
                    blank_next = blank_reg | hit;
                end
                if (cnt_reg == 3'd4)
                begin
                    if (blank_reg | hit)
                    begin
                        res_val_next   = blank_marker;
                        res_blank_next = 1'b1;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        mac_ctrl.acc_clr = 1'b1;
                        step_next        = 4'd0;
                        state_next       = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                mac_ctrl.mul_en  = (step_reg != 4'd8);
                mac_ctrl.acc_add = (step_reg != 4'd0) && !step_reg[0];
                step_next        = step_reg + 4'd1;
                if (step_reg == 4'd8)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                res_val_next   = sat[PIX_W-1:0];
                res_blank_next = 1'b0;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_val_next   = res_val_reg;
                    out_blank_next = res_blank_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        pixel_reg     <= pixel_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        cnt_reg       <= cnt_next;
        step_reg      <= step_next;
        prev_in_reg   <= prev_in_next;
        blank_reg     <= blank_next;
        res_val_reg   <= res_val_next;
        res_blank_reg <= res_blank_next;
        out_val_reg   <= out_val_next;
        out_blank_reg <= out_blank_next;
        if (cap_en)
        begin
            pix_reg[cap_idx] <= cap_val;
        end
    end

endmodule
